// ===== sv/csh_pkg.sv =====
// Shared types and hash arithmetic for the case-folding string hash.
// Used by the front, queue, back and top-level modules; depends on nothing.
package csh_pkg;

  localparam int HashW = 32;
  localparam int CharW = 8;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCntW = 2;

  localparam logic [CharW-1:0] QuoteChar     = 8'h22;
  localparam logic [CharW-1:0] BackslashChar = 8'h5C;
  localparam logic [CharW-1:0] SlashChar     = 8'h2F;
  localparam logic [CharW-1:0] NulChar       = 8'h00;
  localparam logic [CharW-1:0] UpperA        = 8'h41;
  localparam logic [CharW-1:0] UpperZ        = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset    = 8'h20;

  typedef logic [HashW-1:0] hash_t;

  // One command from the front to the back.
  typedef struct packed {
    logic             finish;  // apply final mix and emit
    logic             start;   // first command of a string: start from the seed
    logic             load;    // opening quote: load the seed and absorb nothing
    logic [CharW-1:0] chr;     // folded character, used when not finishing
  } cmd_t;

  typedef struct packed {
    logic started;
    logic quote;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[UpperA:UpperZ]}) begin
      r = c + CaseOffset;
    end else if (c == BackslashChar) begin
      r = SlashChar;
    end
    return r;
  endfunction

  // h += sext(c); h *= 0x401; h ^= h >> 6
  function automatic hash_t absorb(input hash_t h, input logic [CharW-1:0] c);
    hash_t s;
    hash_t m;
    s = h + {{(HashW-CharW){c[CharW-1]}}, c};
    m = s + (s << 10);
    return m ^ (m >> 6);
  endfunction

  // h *= 9; h ^= h >> 11; h *= 0x8001
  function automatic hash_t final_mix(input hash_t h);
    hash_t a;
    hash_t b;
    a = h + (h << 3);
    b = a ^ (a >> 11);
    return b + (b << 15);
  endfunction

endpackage

// ===== sv/csh_front.sv =====
// Front end: accepts character beats, folds case and tracks string framing.
// Depends on csh_pkg; pushes cmd_t commands into csh_queue.
module csh_front import csh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] in_char_byte,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd,
  output front_stat_t      stat
);

  logic started_r, started_nxt;
  logic quote_r, quote_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    started_nxt = started_r;
    quote_nxt   = quote_r;
    push        = 1'b0;
    push_cmd.finish = 1'b0;
    push_cmd.start  = 1'b0;
    push_cmd.load   = 1'b0;
    push_cmd.chr    = fold_char(in_char_byte);
    if (accept) begin
      if (!started_r) begin
        push           = 1'b1;
        push_cmd.start = 1'b1;
        if (in_char_byte == QuoteChar) begin
          // The opening quote only loads the seed, so the seed is taken when
          // the string begins.
          push_cmd.load = 1'b1;
          started_nxt   = 1'b1;
          quote_nxt     = 1'b1;
        end else begin
          quote_nxt = 1'b0;
          if (in_char_byte == NulChar) begin
            push_cmd.finish = 1'b1;
          end else begin
            started_nxt = 1'b1;
          end
        end
      end else begin
        push = 1'b1;
        if (in_char_byte == NulChar || (quote_r && in_char_byte == QuoteChar)) begin
          push_cmd.finish = 1'b1;
          started_nxt     = 1'b0;
          quote_nxt       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      quote_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      quote_r   <= quote_nxt;
    end
  end

  assign stat.started = started_r;
  assign stat.quote   = quote_r;

endmodule

// ===== sv/csh_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on csh_pkg for cmd_t and the queue sizing constants.
module csh_queue import csh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    pop_valid,
  input  logic    pop_ready,
  output cmd_t    pop_cmd,
  output q_stat_t stat
);

  cmd_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCntW'(QDepth));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/csh_back.sv =====
// Back end: holds the seed and running hash, absorbs characters and drives
// the output register with the final mix. Depends on csh_pkg.
module csh_back import csh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [HashW-1:0] cfg_hash_seed,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HashW-1:0] out_hash_value
);

  hash_t seed_r;
  hash_t hash_r, hash_nxt;
  hash_t out_hash_r, out_hash_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  slot_free;
  logic  take;
  hash_t base;

  // An absorb never needs the output slot; a finish waits until it is free.
  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = !cmd.finish || slot_free;
  assign take      = cmd_valid && cmd_ready;
  assign base      = cmd.start ? seed_r : hash_r;

  always_comb begin
    hash_nxt      = hash_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      if (cmd.finish) begin
        out_hash_nxt  = final_mix(base);
        out_valid_nxt = 1'b1;
      end else if (cmd.load) begin
        hash_nxt = base;
      end else begin
        hash_nxt = absorb(base, cmd.chr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_hash_seed;
      end
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ===== sv/case_folding_string_hash_top.sv =====
// Case-folding one-at-a-time string hash, 32 bits.
// Input channel (in_valid/in_ready/in_char_byte) takes one character per beat.
// Letters A-Z fold to lower case and backslash becomes slash before hashing.
// A string ends on a zero byte; a string whose first byte is a double quote
// also ends on the next double quote, and the opening quote is not hashed.
// Each terminator yields one beat on the output channel (out_valid/out_ready/
// out_hash_value) carrying the finished hash; other bytes yield nothing.
// cfg_wr_en/cfg_hash_seed write the seed, which each string starts from;
// write it only while the block is idle.
// Throughput: one character per cycle while in_ready is high. A front end
// frames the string and pushes commands into a two-entry queue; a back end
// absorbs one command per cycle with shift-add logic, except that a terminator
// waits for a free output register, which it then loads with the final hash.
// When the receiver stalls, the output register holds its beat, absorbs keep
// draining, and in_ready drops only once the queue fills behind a pending
// terminator. Synchronous reset clears the seed to zero, framing state and
// queue; the block accepts beats as soon as reset is released.
// Depends on csh_pkg and the csh_front, csh_queue and csh_back modules.
module case_folding_string_hash_top import csh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [HashW-1:0] cfg_hash_seed,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] in_char_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HashW-1:0] out_hash_value
);

  logic        push;
  cmd_t        push_cmd;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_ready;
  q_stat_t     q_stat;
  front_stat_t f_stat;

  csh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .q_full       (q_stat.full),
    .push         (push),
    .push_cmd     (push_cmd),
    .stat         (f_stat)
  );

  csh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd),
    .stat      (q_stat)
  );

  csh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_hash_seed  (cfg_hash_seed),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  // Quoted framing only exists inside a started string.
  a_quote_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.quote |-> f_stat.started)
    else $error("quote mode set outside a string");

  // A seed load only ever opens a string and never emits.
  a_load_is_start: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_cmd.load) |-> (q_cmd.start && !q_cmd.finish))
    else $error("seed load command that does not open a string");

  // The queue never reports full and empty together.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // A terminator must not overwrite a held, untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_cmd.finish) |-> (!out_valid || out_ready))
    else $error("terminator popped while result is stalled");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

// ===== tb/tb_case_folding_string_hash_top.sv =====
// Self-checking bench for case_folding_string_hash_top: a directed table, then
// random strings under three pacing modes, every hash beat checked in order.
// Depends on csh_pkg and the case_folding_string_hash_top RTL.
module tb_case_folding_string_hash_top;
  import csh_pkg::*;

  localparam int StallLimit = 3000;
  localparam int DrainCycles = 6;
  localparam int PhaseChars = 235;
  localparam int NumPhases = 6;
  localparam hash_t AbsorbMul = 32'h0000_0401;
  localparam hash_t MixMulA = 32'h0000_0009;
  localparam hash_t MixMulB = 32'h0000_8001;

  typedef struct packed {
    logic [CharW-1:0] chr;
    logic             known;
    hash_t            hash;
  } char_row_t;

  // Only the two empty strings carry a typed expectation: both are hashed from
  // the reset seed of zero with nothing absorbed, and the final mix of zero is zero.
  localparam char_row_t DirectedRows [24] = '{
    '{NulChar,       1'b1, 32'h0},  // empty string
    '{QuoteChar,     1'b0, 32'h0},
    '{QuoteChar,     1'b1, 32'h0},  // empty quoted string
    '{UpperA,        1'b0, 32'h0},
    '{UpperZ,        1'b0, 32'h0},
    '{8'h40,         1'b0, 32'h0},
    '{8'h5B,         1'b0, 32'h0},
    '{8'h61,         1'b0, 32'h0},
    '{8'h7A,         1'b0, 32'h0},
    '{BackslashChar, 1'b0, 32'h0},
    '{8'hFF,         1'b0, 32'h0},
    '{8'h80,         1'b0, 32'h0},
    '{8'h7F,         1'b0, 32'h0},
    '{8'h01,         1'b0, 32'h0},
    '{QuoteChar,     1'b0, 32'h0},  // plain character inside an unquoted string
    '{NulChar,       1'b0, 32'h0},
    '{QuoteChar,     1'b0, 32'h0},
    '{8'h51,         1'b0, 32'h0},
    '{NulChar,       1'b0, 32'h0},  // zero closes a quoted string
    '{QuoteChar,     1'b0, 32'h0},
    '{8'hFF,         1'b0, 32'h0},
    '{QuoteChar,     1'b0, 32'h0},
    '{8'h4D,         1'b0, 32'h0},  // this string stays open across the seed write
    '{8'h78,         1'b0, 32'h0}
  };

  localparam logic [CharW-1:0] BoundaryChars [8] = '{
    8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'hFF, 8'h01
  };
  localparam hash_t FixedSeeds [3] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [HashW-1:0] cfg_hash_seed = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CharW-1:0] in_char_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [HashW-1:0] out_hash_value;

  // Bench copy of the block's seed and string framing.
  hash_t seed_reg = '0;
  hash_t run_hash = '0;
  bit    in_string = 1'b0;
  bit    quoted = 1'b0;

  hash_t pending_hashes [$];
  hash_t want;
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;
  int    chars_sent = 0;
  int    hashes_seen = 0;
  int    seeds_used = 0;
  int    mismatch_count = 0;
  int    quiet_cycles = 0;

  case_folding_string_hash_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_hash_seed  (cfg_hash_seed),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic hash_t absorb_char(input hash_t h, input logic [CharW-1:0] raw);
    logic [CharW-1:0] c;
    hash_t t;
    c = raw;
    if (raw >= UpperA && raw <= UpperZ) begin
      c = raw + CaseOffset;
    end else if (raw == BackslashChar) begin
      c = SlashChar;
    end
    // The folded byte is added as a signed char.
    t = (h + {{(HashW-CharW){c[CharW-1]}}, c}) * AbsorbMul;
    return t ^ (t >> 6);
  endfunction

  function automatic hash_t finish_hash(input hash_t h);
    hash_t t;
    t = h * MixMulA;
    t = t ^ (t >> 11);
    return t * MixMulB;
  endfunction

  // Advances the framing by one character; done is set on a terminator.
  task automatic track_char(input logic [CharW-1:0] chr, output bit done, output hash_t h);
    done = 1'b0;
    h = '0;
    if (!in_string) begin
      run_hash = seed_reg;
      quoted = (chr == QuoteChar);
      if (quoted) begin
        in_string = 1'b1;
      end else if (chr == NulChar) begin
        done = 1'b1;
        h = finish_hash(run_hash);
      end else begin
        run_hash = absorb_char(run_hash, chr);
        in_string = 1'b1;
      end
    end else if (chr == NulChar || (quoted && chr == QuoteChar)) begin
      done = 1'b1;
      h = finish_hash(run_hash);
      in_string = 1'b0;
      quoted = 1'b0;
    end else begin
      run_hash = absorb_char(run_hash, chr);
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] chr, input bit known, input hash_t known_hash);
    bit done;
    hash_t h;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= chr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    track_char(chr, done, h);
    if (done) begin
      pending_hashes.push_back(known ? known_hash : h);
    end
  endtask

  // Holds the input off until every hash is out and the queue behind has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_seed(input hash_t seed);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_hash_seed <= seed;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg = seed;
    seeds_used++;
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      return CharW'($urandom_range(UpperA, UpperZ));
    end else if (r < 50) begin
      return CharW'($urandom_range(8'h61, 8'h7A));
    end else if (r < 58) begin
      return BackslashChar;
    end else if (r < 63) begin
      return QuoteChar;
    end else if (r < 72) begin
      return BoundaryChars[$urandom_range(7)];
    end
    return CharW'($urandom_range(1, 255));
  endfunction

  task automatic send_random_string();
    int kind;
    int len;
    logic [CharW-1:0] c;
    kind = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
    if (kind < 10) begin
      // Raw bytes of any value, so terminators land anywhere.
      repeat ($urandom_range(1, 6)) send_char(CharW'($urandom_range(255)), 1'b0, '0);
    end else if (kind < 35) begin
      send_char(QuoteChar, 1'b0, '0);
      repeat (len) begin
        do c = pick_char(); while (c == QuoteChar);
        send_char(c, 1'b0, '0);
      end
      send_char(($urandom_range(9) == 0) ? NulChar : QuoteChar, 1'b0, '0);
    end else begin
      for (int i = 0; i < len; i++) begin
        do c = pick_char(); while (i == 0 && c == QuoteChar);
        send_char(c, 1'b0, '0);
      end
      send_char(NulChar, 1'b0, '0);
    end
  endtask

  task automatic run_test();
    int phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 37;
    recv_stall_pct = 80;
    foreach (DirectedRows[i]) begin
      send_char(DirectedRows[i].chr, DirectedRows[i].known, DirectedRows[i].hash);
    end
    for (int p = 0; p < NumPhases; p++) begin
      write_seed((p % 2) ? hash_t'($urandom()) : FixedSeeds[p / 2]);
      send_gap_pct = (p < 2) ? 37 : (p < 4) ? 80 : 0;
      recv_stall_pct = (p < 2) ? 80 : (p < 4) ? 37 : 0;
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars) send_random_string();
    end
    drain();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      hashes_seen++;
      if (pending_hashes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected hash beat %h with no string pending", out_hash_value);
        end
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash_value !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("hash_value mismatch: expected %h, got %h", want, out_hash_value);
          end
        end
      end
    end
  end

  initial begin
    fork
      run_test();
      wait (quiet_cycles >= StallLimit);
    join_any
    if (quiet_cycles >= StallLimit) begin
      mismatch_count++;
      $display("Timeout: no beat moved for %0d cycles", StallLimit);
    end
    $display("Sent %0d characters and checked %0d hashes under %0d written seeds,",
             chars_sent, hashes_seen, seeds_used);
    $display("mixing quoted, unquoted and noise strings with three pacing modes.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/csh_pkg.sv
sv/csh_front.sv
sv/csh_queue.sv
sv/csh_back.sv
sv/case_folding_string_hash_top.sv
tb/tb_case_folding_string_hash_top.sv
